// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PSF_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PSF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/psf_pkg.sv =====
package psf_pkg;

   localparam int DATA_W         = 32;
   localparam int MAX_PRIMES_DEF = 64;
   localparam int DIV_STEPS      = DATA_W;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_rsp_type;

endpackage

// ===== rtl/psf_divider.sv =====
// restoring remainder unit, one quotient bit per cycle
module psf_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  psf_pkg::div_req_type div_req,
   output psf_pkg::div_rsp_type div_rsp
);

   logic [psf_pkg::DATA_W-1:0]    dvd_ff, dvd_in;
   logic [psf_pkg::DATA_W-1:0]    dsr_ff, dsr_in;
   logic [psf_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [psf_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          done_ff, done_in;
   logic [psf_pkg::DATA_W:0]      trial;
   logic [psf_pkg::DATA_W:0]      diff;

   always_comb begin
      trial   = {rem_ff, dvd_ff[psf_pkg::DATA_W-1]};
      diff    = trial - {1'b0, dsr_ff};
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         dsr_in = div_req.divisor;
         rem_in = '0;
         cnt_in = psf_pkg::DIV_CNT_W'(psf_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         dvd_in = {dvd_ff[psf_pkg::DATA_W-2:0], 1'b0};
         // no borrow means the divisor fits into the partial remainder
         if (!diff[psf_pkg::DATA_W]) begin
            rem_in = diff[psf_pkg::DATA_W-1:0];
         end else begin
            rem_in = trial[psf_pkg::DATA_W-1:0];
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == psf_pkg::DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.rem_zero = (rem_ff == '0);

endmodule

// ===== rtl/psf_table.sv =====
// prime store, one write and one registered read per cycle
module psf_table #(
   parameter int DEPTH = psf_pkg::MAX_PRIMES_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic [psf_pkg::DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]           rd_addr,
   output logic [psf_pkg::DATA_W-1:0] rd_data
);

   logic [psf_pkg::DATA_W-1:0] mem [DEPTH];
   logic [psf_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/prime_sieve_filter_core.sv =====
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_candidate[31:0]
// rsp       out        rsp_valid/rsp_stall  rsp_prime_value[31:0], rsp_unverified
//
// an item is tested against each stored prime in turn, from the first entry up;
// each test is a table read, a divider start, 32 remainder steps and a done flag
// a divisible candidate ends the scan early and gives no item on rsp
// reset clears the prime count; table entries are only read below the count
// req_stall is high while an item is in work; a stalled rsp item holds the next one
module prime_sieve_filter_core #(
   parameter int MAX_PRIMES = psf_pkg::MAX_PRIMES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [psf_pkg::DATA_W-1:0] req_candidate,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [psf_pkg::DATA_W-1:0] rsp_prime_value,
   output logic                       rsp_unverified
);

   localparam int IDX_W = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
   localparam int CNT_W = $clog2(MAX_PRIMES + 1);

   psf_pkg::state_type          state_ff, state_in;
   logic [psf_pkg::DATA_W-1:0]  cand_ff, cand_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [psf_pkg::DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                        rsp_unver_ff, rsp_unver_in;
   logic [CNT_W-1:0]            next_idx;
   logic                        full;
   logic                        wr_en;
   logic [psf_pkg::DATA_W-1:0]  rd_data;
   psf_pkg::div_req_type        div_req;
   psf_pkg::div_rsp_type        div_rsp;

   psf_table #(
      .DEPTH (MAX_PRIMES),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (cand_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   psf_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign full     = (count_ff == CNT_W'(MAX_PRIMES));
   assign next_idx = CNT_W'(idx_ff) + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psf_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cand_ff      <= cand_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_unver_ff <= rsp_unver_in;
   end

   always_comb begin
      state_in         = state_ff;
      cand_in          = cand_ff;
      idx_in           = idx_ff;
      count_in         = count_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_value_in     = rsp_value_ff;
      rsp_unver_in     = rsp_unver_ff;
      wr_en            = 1'b0;
      req_stall        = 1'b1;
      div_req.start    = 1'b0;
      div_req.dividend = cand_ff;
      div_req.divisor  = rd_data;
      unique case (state_ff)
         psf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cand_in = req_candidate;
               idx_in  = '0;
               // zero and one are dropped without a scan
               if (req_candidate[psf_pkg::DATA_W-1:1] != '0) begin
                  state_in = (count_ff == '0) ? psf_pkg::ST_EMIT : psf_pkg::ST_READ;
               end
            end
         end
         psf_pkg::ST_READ: begin
            state_in = psf_pkg::ST_START;
         end
         psf_pkg::ST_START: begin
            div_req.start = 1'b1;
            state_in      = psf_pkg::ST_WAIT;
         end
         psf_pkg::ST_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.rem_zero) begin
                  state_in = psf_pkg::ST_IDLE;
               end else if (next_idx == count_ff) begin
                  state_in = psf_pkg::ST_EMIT;
               end else begin
                  idx_in   = next_idx[IDX_W-1:0];
                  state_in = psf_pkg::ST_READ;
               end
            end
         end
         psf_pkg::ST_EMIT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = cand_ff;
               rsp_unver_in = full;
               if (!full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               state_in = psf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psf_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign rsp_unverified  = rsp_unver_ff;

endmodule

// ===== rtl/psf_checker.sv =====
`include "assert_macros.svh"

module psf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic [psf_pkg::DATA_W-1:0] req_candidate,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [psf_pkg::DATA_W-1:0] rsp_prime_value,
   input logic                       rsp_unverified
);

   // a stalled result holds
   `PSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_prime_value) && $stable(rsp_unverified))

   // a candidate of two or more keeps the block busy the next cycle
   `PSF_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall && (req_candidate > 32'd1), req_stall)

   // a new result only follows a busy cycle
   `PSF_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // zero and one are never emitted
   `PSF_ASSERT_NOW(a_rsp_value_range, clock, reset, rsp_valid, rsp_prime_value > 32'd1)

   // no result right after reset
   `PSF_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind prime_sieve_filter_core psf_checker u_psf_checker (.*);
